/* rtl/tcw_pkg.sv */
// Shared types and constants for the text console writer.
package tcw_pkg;

  // Fixed field widths of the item and result beats
  localparam int CHAR_W   = 8;
  localparam int ATTR_W   = 8;
  localparam int COL_W    = 7;
  localparam int ROW_W    = 5;
  localparam int CURSOR_W = 11;
  localparam int CELL_DW  = CHAR_W + ATTR_W;

  // Command queue and result queue depth
  localparam int QUEUE_DEPTH = 2;

  // Input action codes
  localparam logic [1:0] ACT_PUT   = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  // Character codes
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;

  // Reset value of the default attribute register
  localparam logic [ATTR_W-1:0] DEFAULT_ATTR_RST = 8'd15;

  // Decoded operation handed from the front end to the back end
  typedef enum logic [2:0] {
    OP_PUT     = 3'd0,
    OP_NEWLINE = 3'd1,
    OP_READ    = 3'd2,
    OP_CLEAR   = 3'd3,
    OP_NOP     = 3'd4
  } op_t;

  // One classified command; column and row are already saturated
  typedef struct packed {
    op_t               op;
    logic [CHAR_W-1:0] char_code;
    logic [ATTR_W-1:0] attr;
    logic              at_position;
    logic [COL_W-1:0]  column;
    logic [ROW_W-1:0]  row_index;
  } cmd_t;

  // One result beat
  typedef struct packed {
    logic [CURSOR_W-1:0] cursor_cell;
    logic                scrolled;
    logic [CHAR_W-1:0]   cell_char;
    logic [ATTR_W-1:0]   cell_attribute;
  } res_t;

endpackage

/* rtl/text_console_writer.sv */
// Text console writer top level: front end, command queue, back end, result queue.
// The back end sequencer takes a put, newline or no-op through idle, address, execute and result;
// a read adds a read wait, a clear sweeps every cell, and a scroll copies the rows up, drains the
// last copy write and zeroes the bottom row. The result step holds while the result queue is full,
// and a new command is taken only in idle. Reset (synchronous, rst_n low): cursor homes, default
// attribute becomes 15, and a pass over every cell zeroes the screen, full high.
module text_console_writer
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_write_en,
  input  logic [ATTR_W-1:0]   cfg_write_data,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          in_action,
  input  logic [CHAR_W-1:0]   in_char_code,
  input  logic [ATTR_W-1:0]   in_attribute,
  input  logic                in_at_position,
  input  logic [COL_W-1:0]    in_column,
  input  logic [ROW_W-1:0]    in_row_index,
  output logic                empty,
  input  logic                pop,
  output logic [CURSOR_W-1:0] out_cursor_cell,
  output logic                out_scrolled,
  output logic [CHAR_W-1:0]   out_cell_char,
  output logic [ATTR_W-1:0]   out_cell_attribute
);

  cmd_t              front_cmd, back_cmd;
  logic [ATTR_W-1:0] default_attr;
  logic              cmd_full, cmd_empty, cmd_pop;
  logic              res_full, res_push;
  res_t              back_res, out_res;
  logic              init_busy;

  assign full = cmd_full || init_busy;

  tcw_front #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .in_action     (in_action),
    .in_char_code  (in_char_code),
    .in_attribute  (in_attribute),
    .in_at_position(in_at_position),
    .in_column     (in_column),
    .in_row_index  (in_row_index),
    .cmd           (front_cmd),
    .default_attr  (default_attr)
  );

  // command queue between front and back end
  tcw_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_cmd_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push && !full),
    .push_data(front_cmd),
    .full     (cmd_full),
    .pop      (cmd_pop),
    .pop_data (back_cmd),
    .empty    (cmd_empty)
  );

  tcw_back #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .default_attr(default_attr),
    .cmd         (back_cmd),
    .cmd_empty   (cmd_empty),
    .cmd_pop     (cmd_pop),
    .res         (back_res),
    .res_full    (res_full),
    .res_push    (res_push),
    .init_busy   (init_busy)
  );

  // result queue toward the consumer
  tcw_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_res_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_push),
    .push_data(back_res),
    .full     (res_full),
    .pop      (pop),
    .pop_data (out_res),
    .empty    (empty)
  );

  assign out_cursor_cell    = out_res.cursor_cell;
  assign out_scrolled       = out_res.scrolled;
  assign out_cell_char      = out_res.cell_char;
  assign out_cell_attribute = out_res.cell_attribute;

endmodule

/* rtl/tcw_fifo.sv */
// Small register-based queue used between the console stages.
module tcw_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] data_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = data_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      data_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* rtl/tcw_front.sv */
// Front end: default attribute register and item classification.
module tcw_front
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_write_en,
  input  logic [ATTR_W-1:0] cfg_write_data,
  input  logic [1:0]        in_action,
  input  logic [CHAR_W-1:0] in_char_code,
  input  logic [ATTR_W-1:0] in_attribute,
  input  logic              in_at_position,
  input  logic [COL_W-1:0]  in_column,
  input  logic [ROW_W-1:0]  in_row_index,
  output cmd_t              cmd,
  output logic [ATTR_W-1:0] default_attr
);

  logic [ATTR_W-1:0] default_attr_r;

  // default attribute register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_attr_r <= DEFAULT_ATTR_RST;
    end else if (cfg_write_en) begin
      default_attr_r <= cfg_write_data;
    end
  end

  assign default_attr = default_attr_r;

  // decode action, resolve attribute, saturate position
  always_comb begin
    unique case (in_action)
      ACT_PUT: begin
        cmd.op = (in_char_code == NEWLINE_CODE) ? OP_NEWLINE : OP_PUT;
      end
      ACT_READ:  cmd.op = OP_READ;
      ACT_CLEAR: cmd.op = OP_CLEAR;
      default:   cmd.op = OP_NOP;
    endcase
    cmd.char_code   = in_char_code;
    cmd.attr        = (in_attribute == '0) ? default_attr_r : in_attribute;
    cmd.at_position = in_at_position;
    cmd.column      = (int'(in_column) >= COLUMNS) ? COL_W'(COLUMNS - 1) : in_column;
    cmd.row_index   = (int'(in_row_index) >= ROWS) ? ROW_W'(ROWS - 1) : in_row_index;
  end

endmodule

/* rtl/tcw_back.sv */
// Back end: screen memory, cursor and the sweep sequencer.
module tcw_back
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [ATTR_W-1:0] default_attr,
  input  cmd_t              cmd,
  input  logic              cmd_empty,
  output logic              cmd_pop,
  output res_t              res,
  input  logic              res_full,
  output logic              res_push,
  output logic              init_busy
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int CELL_W = $clog2(CELLS);
  localparam int CW     = $clog2(COLUMNS);
  localparam int RW     = $clog2(ROWS);

  typedef enum logic [9:0] {
    S_INIT   = 10'b00_0000_0001,
    S_IDLE   = 10'b00_0000_0010,
    S_ADDR   = 10'b00_0000_0100,
    S_EXEC   = 10'b00_0000_1000,
    S_RDWAIT = 10'b00_0001_0000,
    S_CLEAR  = 10'b00_0010_0000,
    S_COPY   = 10'b00_0100_0000,
    S_DRAIN  = 10'b00_1000_0000,
    S_ZERO   = 10'b01_0000_0000,
    S_RESULT = 10'b10_0000_0000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CELL_W-1:0]   sweep_r;
  cmd_t                cmd_r;
  logic [RW-1:0]       tgt_row_r, cur_row_r;
  logic [CW-1:0]       tgt_col_r, cur_col_r;
  logic [CELL_W-1:0]   addr_r;
  logic                scrolled_r;
  logic [CHAR_W-1:0]   rd_char_r;
  logic [ATTR_W-1:0]   rd_attr_r;
  logic                cp_valid_r;
  logic [CELL_W-1:0]   cp_addr_r;

  logic [CELL_DW-1:0]  mem [CELLS];
  logic [CELL_DW-1:0]  rd_data_r;
  logic                mem_we, mem_re;
  logic [CELL_W-1:0]   mem_wa, mem_ra;
  logic [CELL_DW-1:0]  mem_wd;

  logic [RW-1:0]       sel_row;
  logic [CW-1:0]       sel_col;
  logic [CELL_W-1:0]   cur_idx;
  logic                wrap;
  logic                sweep_last;
  logic                copy_last;

  assign init_busy  = (state_r == S_INIT);
  assign sweep_last = (sweep_r == CELL_W'(CELLS - 1));
  assign copy_last  = (sweep_r == CELL_W'(CELLS - COLUMNS - 1));

  // target cell: given position or cursor
  assign sel_row = cmd_r.at_position ? RW'(cmd_r.row_index) : cur_row_r;
  assign sel_col = cmd_r.at_position ? CW'(cmd_r.column) : cur_col_r;

  // cursor cell index for the result beat
  assign cur_idx = CELL_W'(cur_row_r) * CELL_W'(COLUMNS) + CELL_W'(cur_col_r);

  // cursor leaves the row after this put
  assign wrap = (cmd_r.op == OP_NEWLINE) || (tgt_col_r == CW'(COLUMNS - 1));

  // memory port control
  always_comb begin
    mem_we = 1'b0;
    mem_wa = sweep_r;
    mem_wd = '0;
    mem_re = 1'b0;
    mem_ra = addr_r;
    unique case (state_r)
      S_INIT: begin
        mem_we = 1'b1;
      end
      S_EXEC: begin
        mem_wa = addr_r;
        mem_wd = {cmd_r.attr, cmd_r.char_code};
        mem_we = (cmd_r.op == OP_PUT);
        mem_re = (cmd_r.op == OP_READ);
      end
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wd = {default_attr, SPACE_CODE};
      end
      S_COPY: begin
        mem_re = 1'b1;
        mem_ra = sweep_r + CELL_W'(COLUMNS);
        mem_we = cp_valid_r;
        mem_wa = cp_addr_r;
        mem_wd = rd_data_r;
      end
      S_DRAIN: begin
        mem_we = cp_valid_r;
        mem_wa = cp_addr_r;
        mem_wd = rd_data_r;
      end
      S_ZERO: begin
        mem_we = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // screen memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data_r <= mem[mem_ra];
    end
  end

  // handshakes with the queues
  assign cmd_pop  = (state_r == S_IDLE) && !cmd_empty;
  assign res_push = (state_r == S_RESULT) && !res_full;

  always_comb begin
    res.cursor_cell    = CURSOR_W'(cur_idx);
    res.scrolled       = scrolled_r;
    res.cell_char      = rd_char_r;
    res.cell_attribute = rd_attr_r;
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT:   if (sweep_last) state_nxt = S_IDLE;
      S_IDLE:   if (!cmd_empty) state_nxt = S_ADDR;
      S_ADDR:   state_nxt = S_EXEC;
      S_EXEC: begin
        case (cmd_r.op)
          OP_PUT, OP_NEWLINE: begin
            state_nxt = (wrap && tgt_row_r == RW'(ROWS - 1)) ? S_COPY : S_RESULT;
          end
          OP_READ:  state_nxt = S_RDWAIT;
          OP_CLEAR: state_nxt = S_CLEAR;
          default:  state_nxt = S_RESULT;
        endcase
      end
      S_RDWAIT: state_nxt = S_RESULT;
      S_CLEAR:  if (sweep_last) state_nxt = S_RESULT;
      S_COPY:   if (copy_last) state_nxt = S_DRAIN;
      S_DRAIN:  state_nxt = S_ZERO;
      S_ZERO:   if (sweep_last) state_nxt = S_RESULT;
      S_RESULT: if (!res_full) state_nxt = S_IDLE;
      default:  state_nxt = S_INIT;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_INIT;
      sweep_r    <= '0;
      cur_row_r  <= '0;
      cur_col_r  <= '0;
      cp_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cp_valid_r <= (state_r == S_COPY);
      case (state_r)
        S_INIT, S_CLEAR, S_ZERO: begin
          sweep_r <= sweep_last ? '0 : sweep_r + 1'b1;
        end
        S_EXEC: begin
          sweep_r <= '0;
          if (cmd_r.op == OP_PUT || cmd_r.op == OP_NEWLINE) begin
            if (!wrap) begin
              cur_row_r <= tgt_row_r;
              cur_col_r <= tgt_col_r + 1'b1;
            end else begin
              cur_col_r <= '0;
              cur_row_r <= (tgt_row_r == RW'(ROWS - 1)) ? tgt_row_r : tgt_row_r + 1'b1;
            end
          end else if (cmd_r.op == OP_CLEAR) begin
            cur_row_r <= '0;
            cur_col_r <= '0;
          end
        end
        S_COPY: begin
          sweep_r <= sweep_r + 1'b1;
        end
        S_DRAIN: begin
          sweep_r <= CELL_W'(CELLS - COLUMNS);
        end
        default: begin
          sweep_r <= sweep_r;
        end
      endcase
    end
  end

  // per-item payload registers
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cmd_r      <= cmd;
      scrolled_r <= 1'b0;
      rd_char_r  <= '0;
      rd_attr_r  <= '0;
    end
    if (state_r == S_ADDR) begin
      tgt_row_r <= sel_row;
      tgt_col_r <= sel_col;
      addr_r    <= CELL_W'(sel_row) * CELL_W'(COLUMNS) + CELL_W'(sel_col);
    end
    if (state_r == S_EXEC && wrap && tgt_row_r == RW'(ROWS - 1) &&
        (cmd_r.op == OP_PUT || cmd_r.op == OP_NEWLINE)) begin
      scrolled_r <= 1'b1;
    end
    if (state_r == S_RDWAIT) begin
      rd_char_r <= rd_data_r[CHAR_W-1:0];
      rd_attr_r <= rd_data_r[CELL_DW-1:CHAR_W];
    end
    if (state_r == S_COPY) begin
      cp_addr_r <= sweep_r;
    end
  end

  // checks
  a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(cur_row_r) < ROWS) && (int'(cur_col_r) < COLUMNS))
    else $error("cursor outside the screen");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (int'(mem_wa) < CELLS))
    else $error("screen write address out of range");

  a_copy_write_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ZERO) |-> !cp_valid_r)
    else $error("scroll copy write still pending while zeroing bottom row");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |=> (state_r == S_ADDR))
    else $error("command taken outside idle");

  a_one_result_per_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |=> (state_r == S_IDLE))
    else $error("result beat not followed by idle");

endmodule

/* bench/tb_text_console_writer.sv */
// Self-checking testbench for the text console writer: screen scoreboard, stimulus and checks.
`timescale 1ns / 100ps

module tb_text_console_writer;
  import tcw_pkg::*;

  localparam int SCREEN_COLS  = 80;
  localparam int SCREEN_ROWS  = 25;
  localparam int SCREEN_CELLS = SCREEN_COLS * SCREEN_ROWS;
  localparam int BOTTOM_ROW   = SCREEN_ROWS - 1;

  // Action code 3 is a no-op; the package names only the first three
  localparam logic [1:0] ACT_NOP = 2'd3;

  localparam int QUIET_LIMIT  = 20000;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 250;
  localparam int PHASES       = 6;
  localparam int TAIL_CYCLES  = 32;

  // One command beat as driven on the in_ ports
  typedef struct {
    logic [1:0]        action;
    logic [CHAR_W-1:0] char_code;
    logic [ATTR_W-1:0] attribute;
    logic              at_position;
    logic [COL_W-1:0]  column;
    logic [ROW_W-1:0]  row_index;
  } console_cmd_t;

  // Screen model and queue of expected result beats
  class console_scoreboard;
    logic [CELL_DW-1:0] screen [SCREEN_CELLS];
    int unsigned        cursor;
    logic [ATTR_W-1:0]  dflt_attr;
    res_t               expected_q[$];
    int unsigned        checked;
    int unsigned        mismatches;
    int unsigned        scrolls;
    int unsigned        clears;

    function new();
      foreach (screen[i]) screen[i] = '0;
      cursor     = 0;
      dflt_attr  = DEFAULT_ATTR_RST;
      checked    = 0;
      mismatches = 0;
      scrolls    = 0;
      clears     = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Addressed cell: explicit position saturates to the screen, else the cursor
    function int unsigned cell_index(console_cmd_t c);
      int unsigned col;
      int unsigned row;
      if (!c.at_position) return cursor;
      col = c.column;
      row = c.row_index;
      if (col >= SCREEN_COLS) col = SCREEN_COLS - 1;
      if (row >= SCREEN_ROWS) row = SCREEN_ROWS - 1;
      return row * SCREEN_COLS + col;
    endfunction

    // Apply one accepted command to the model and queue its result
    function void note_item(console_cmd_t c);
      res_t              r;
      int unsigned       pos;
      logic [ATTR_W-1:0] attr;
      r = '0;
      case (c.action)
        ACT_PUT: begin
          pos  = cell_index(c);
          attr = (c.attribute == '0) ? dflt_attr : c.attribute;
          if (c.char_code == NEWLINE_CODE) begin
            pos = (pos / SCREEN_COLS) * SCREEN_COLS + (SCREEN_COLS - 1);
          end else begin
            screen[pos] = {attr, c.char_code};
          end
          pos++;
          // past the last cell: move every row up, blank the bottom one
          if (pos >= SCREEN_CELLS) begin
            for (int i = 0; i < SCREEN_CELLS - SCREEN_COLS; i++)
              screen[i] = screen[i + SCREEN_COLS];
            for (int i = SCREEN_CELLS - SCREEN_COLS; i < SCREEN_CELLS; i++)
              screen[i] = '0;
            pos -= SCREEN_COLS;
            r.scrolled = 1'b1;
            scrolls++;
          end
          cursor = pos;
        end
        ACT_READ: begin
          pos              = cell_index(c);
          r.cell_char      = screen[pos][CHAR_W-1:0];
          r.cell_attribute = screen[pos][CELL_DW-1:CHAR_W];
        end
        ACT_CLEAR: begin
          foreach (screen[i]) screen[i] = {dflt_attr, SPACE_CODE};
          cursor = 0;
          clears++;
        end
        default: ;
      endcase
      r.cursor_cell = CURSOR_W'(cursor);
      expected_q.push_back(r);
    endfunction

    // Compare one popped beat with the oldest expectation
    function void check_result(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected: cursor_cell %0d", got.cursor_cell);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.cursor_cell !== want.cursor_cell) begin
        $error("cursor_cell: expected %0d, actual %0d", want.cursor_cell, got.cursor_cell);
        mismatches++;
      end
      if (got.scrolled !== want.scrolled) begin
        $error("scrolled: expected %0d, actual %0d", want.scrolled, got.scrolled);
        mismatches++;
      end
      if (got.cell_char !== want.cell_char) begin
        $error("cell_char: expected 0x%02h, actual 0x%02h", want.cell_char, got.cell_char);
        mismatches++;
      end
      if (got.cell_attribute !== want.cell_attribute) begin
        $error("cell_attribute: expected 0x%02h, actual 0x%02h",
               want.cell_attribute, got.cell_attribute);
        mismatches++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                cfg_write_en;
  logic [ATTR_W-1:0]   cfg_write_data;
  logic                push;
  logic                full;
  logic [1:0]          in_action;
  logic [CHAR_W-1:0]   in_char_code;
  logic [ATTR_W-1:0]   in_attribute;
  logic                in_at_position;
  logic [COL_W-1:0]    in_column;
  logic [ROW_W-1:0]    in_row_index;
  logic                empty;
  logic                pop;
  logic [CURSOR_W-1:0] out_cursor_cell;
  logic                out_scrolled;
  logic [CHAR_W-1:0]   out_cell_char;
  logic [ATTR_W-1:0]   out_cell_attribute;

  console_scoreboard sb;
  bit                idle_on = 1'b1;
  int unsigned       items_sent = 0;

  text_console_writer #(
    .COLUMNS(SCREEN_COLS),
    .ROWS   (SCREEN_ROWS)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_write_en      (cfg_write_en),
    .cfg_write_data    (cfg_write_data),
    .push              (push),
    .full              (full),
    .in_action         (in_action),
    .in_char_code      (in_char_code),
    .in_attribute      (in_attribute),
    .in_at_position    (in_at_position),
    .in_column         (in_column),
    .in_row_index      (in_row_index),
    .empty             (empty),
    .pop               (pop),
    .out_cursor_cell   (out_cursor_cell),
    .out_scrolled      (out_scrolled),
    .out_cell_char     (out_cell_char),
    .out_cell_attribute(out_cell_attribute)
  );

  // 8 ns clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned idle_gap();
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic console_cmd_t make_cmd(logic [1:0] action, logic [CHAR_W-1:0] ch,
                                            logic [ATTR_W-1:0] attr, logic at_pos,
                                            logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
    console_cmd_t c;
    c.action      = action;
    c.char_code   = ch;
    c.attribute   = attr;
    c.at_position = at_pos;
    c.column      = col;
    c.row_index   = row;
    return c;
  endfunction

  // Pick a cell: bottom row and the cursor's neighborhood are favored
  function automatic console_cmd_t aimed(console_cmd_t c);
    int unsigned r;
    int unsigned crow;
    r    = $urandom_range(0, 9);
    crow = sb.cursor / SCREEN_COLS;
    c.at_position = 1'b1;
    c.column = ($urandom_range(0, 9) == 0) ? COL_W'($urandom_range(SCREEN_COLS, 127))
                                           : COL_W'($urandom_range(0, SCREEN_COLS - 1));
    if (r < 3)      c.row_index = ROW_W'(BOTTOM_ROW);
    else if (r < 6) c.row_index = ROW_W'($urandom_range(0, BOTTOM_ROW));
    else if (r < 9) c.row_index = ROW_W'((crow > 0 && r == 8) ? crow - 1 : crow);
    else            c.row_index = ROW_W'($urandom_range(SCREEN_ROWS, 31));
    return c;
  endfunction

  // Random command: mostly text runs at the cursor so the screen fills and scrolls
  function automatic console_cmd_t random_cmd();
    console_cmd_t c;
    int unsigned  pick;
    c = make_cmd(ACT_PUT, CHAR_W'($urandom_range(0, 255)),
                 ($urandom_range(0, 3) == 0) ? '0 : ATTR_W'($urandom_range(1, 255)),
                 1'b0, COL_W'($urandom_range(0, 127)), ROW_W'($urandom_range(0, 31)));
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      if ($urandom_range(0, 4) == 0) c.char_code = NEWLINE_CODE;
    end else if (pick < 70) begin
      c = aimed(c);
      if ($urandom_range(0, 7) == 0) c.char_code = NEWLINE_CODE;
    end else if (pick < 92) begin
      c.action = ACT_READ;
      if ($urandom_range(0, 3) != 0) c = aimed(c);
    end else if (pick < 95) begin
      c.action = ACT_CLEAR;
      c.at_position = 1'($urandom_range(0, 1));
    end else begin
      c.action = ACT_NOP;
      c.at_position = 1'($urandom_range(0, 1));
    end
    return c;
  endfunction

  // Offer one command beat; called and returning at a falling edge
  task automatic push_item(input console_cmd_t c);
    int unsigned gap;
    push           <= 1'b1;
    in_action      <= c.action;
    in_char_code   <= c.char_code;
    in_attribute   <= c.attribute;
    in_at_position <= c.at_position;
    in_column      <= c.column;
    in_row_index   <= c.row_index;
    do @(posedge clk); while (full);
    sb.note_item(c);
    items_sent++;
    @(negedge clk);
    gap = idle_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Stop offering and wait until every expected beat has come back
  task automatic drain();
    push <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic write_default_attr(input logic [ATTR_W-1:0] value);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    sb.dflt_attr = value;
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  // Stimulus
  initial begin
    logic [ATTR_W-1:0] phase_attr [PHASES];
    sb             = new();
    rst_n          = 1'b0;
    cfg_write_en   = 1'b0;
    cfg_write_data = '0;
    push           = 1'b0;
    in_action      = ACT_PUT;
    in_char_code   = '0;
    in_attribute   = '0;
    in_at_position = 1'b0;
    in_column      = '0;
    in_row_index   = '0;
    phase_attr[0]  = 8'hFF;
    phase_attr[1]  = 8'h00;
    phase_attr[2]  = ATTR_W'($urandom_range(0, 255));
    phase_attr[3]  = 8'h01;
    phase_attr[4]  = ATTR_W'($urandom_range(0, 255));
    phase_attr[5]  = DEFAULT_ATTR_RST;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // directed, reset default attribute
    push_item(make_cmd(ACT_READ, 8'h00, 8'h00, 1'b1, 0, 0));
    push_item(make_cmd(ACT_PUT, 8'h41, 8'h00, 1'b0, 7'h7F, 5'h1F));
    push_item(make_cmd(ACT_PUT, 8'hFF, 8'hFF, 1'b1, 79, 24));
    push_item(make_cmd(ACT_READ, 8'h00, 8'h00, 1'b1, 79, 23));
    push_item(make_cmd(ACT_READ, 8'h00, 8'h00, 1'b1, 7'h7F, 5'h1F));
    push_item(make_cmd(ACT_PUT, 8'h00, 8'h01, 1'b1, 0, 0));
    push_item(make_cmd(ACT_PUT, NEWLINE_CODE, 8'h00, 1'b0, 0, 0));
    push_item(make_cmd(ACT_PUT, NEWLINE_CODE, 8'h33, 1'b1, 5, 3));
    push_item(make_cmd(ACT_PUT, 8'h7F, 8'h80, 1'b1, 100, 3));
    push_item(make_cmd(ACT_PUT, 8'h5A, 8'h24, 1'b1, 10, 30));
    push_item(make_cmd(ACT_READ, 8'h00, 8'h00, 1'b1, 79, 3));
    push_item(make_cmd(ACT_READ, 8'h00, 8'h00, 1'b0, 0, 0));
    push_item(make_cmd(ACT_NOP, 8'hFF, 8'hFF, 1'b1, 7'h7F, 5'h1F));
    push_item(make_cmd(ACT_CLEAR, 8'h00, 8'h00, 1'b0, 0, 0));
    push_item(make_cmd(ACT_READ, 8'h00, 8'h00, 1'b1, 40, 12));
    push_item(make_cmd(ACT_PUT, 8'h55, 8'hAA, 1'b0, 0, 0));

    // both attributes zero
    drain();
    write_default_attr(8'h00);
    push_item(make_cmd(ACT_PUT, 8'h2A, 8'h00, 1'b1, 1, 1));
    push_item(make_cmd(ACT_READ, 8'h00, 8'h00, 1'b1, 1, 1));
    push_item(make_cmd(ACT_CLEAR, 8'h00, 8'h00, 1'b1, 0, 0));
    push_item(make_cmd(ACT_READ, 8'h00, 8'h00, 1'b1, 79, 24));

    // all-ones default attribute on clear and put
    drain();
    write_default_attr(8'hFF);
    push_item(make_cmd(ACT_CLEAR, 8'h00, 8'h00, 1'b0, 0, 0));
    push_item(make_cmd(ACT_PUT, 8'h20, 8'h00, 1'b0, 0, 0));
    push_item(make_cmd(ACT_READ, 8'h00, 8'h00, 1'b1, 0, 0));

    // random phases, one default attribute each; phase 2 runs without idling
    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_default_attr(phase_attr[p]);
      idle_on = (p != 2);
      repeat (PHASE_ITEMS) push_item(random_cmd());
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d commands, checked %0d result beats, %0d mismatches.",
             items_sent, sb.checked, sb.mismatches);
    $display("Saw %0d scrolls and %0d clears over eight default attribute settings.",
             sb.scrolls, sb.clears);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_text_console_writer passed");
    end else begin
      $display("tb_text_console_writer failed");
    end
    $finish;
  end

  // Result side: random pops, with two long hold-offs so the block backs up
  initial begin : result_sink
    int unsigned stall_left;
    res_t        got;
    stall_left = 0;
    pop        = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
      end
      @(posedge clk);
      if (pop && !empty) begin
        got = {out_cursor_cell, out_scrolled, out_cell_char, out_cell_attribute};
        sb.check_result(got);
        if (sb.checked == 200 || sb.checked == 1000) stall_left = HOLD_CYCLES;
        else stall_left = idle_gap();
      end
    end
  end

  // Watchdog: end the run if no beat moves on either side for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $error("no beat accepted for %0d cycles", quiet);
        $display("tb_text_console_writer failed");
        $finish;
      end
    end
  end

endmodule
